// ===== rtl/core/thk_pkg.sv =====
// thk_pkg: shared constants, register indexes and the result beat type
// for the thick line rasteriser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package thk_pkg;

    localparam int CFG_W     = 13;   // frame_width / frame_height
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W    = 24;
    localparam int COLOR_W   = 32;
    localparam int THICK_W   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1024;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd768;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               we;
        logic               last;
    } thk_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/thk_walk.sv =====
// thk_walk: line state, Bresenham stepping and square brush scan.
// Depends on thk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thk_walk
    import thk_pkg::*;
#(
    parameter int COORD_BITS    = 13,
    parameter int MAX_THICKNESS = 63,
    localparam int HALF_MAX     = MAX_THICKNESS / 2,
    localparam int HB           = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1,
    localparam int SW           = ((COORD_BITS > HB + 1) ? COORD_BITS : HB + 1) + 1
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          step,
    input  wire                          op,
    input  wire signed [COORD_BITS-1:0]  start_x,
    input  wire signed [COORD_BITS-1:0]  start_y,
    input  wire signed [COORD_BITS-1:0]  end_x,
    input  wire signed [COORD_BITS-1:0]  end_y,
    input  wire        [COLOR_W-1:0]     color,
    input  wire        [THICK_W-1:0]     thickness,
    output logic                         pix_valid,
    output logic signed [SW-1:0]         pix_x,
    output logic signed [SW-1:0]         pix_y,
    output logic        [COLOR_W-1:0]    pix_color,
    output logic                         pix_last
);

    localparam int C   = COORD_BITS;
    localparam int EW  = C + 3;
    localparam int TCW = 9;

    logic                 active_reg, active_next;
    logic signed [C-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [C-1:0]  tx_reg, tx_next, ty_reg, ty_next;
    logic        [C-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic        [1:0]    signs_reg, signs_next;   // bit 0 x down, bit 1 y down
    logic signed [EW-1:0] err_reg, err_next;
    logic signed [HB:0]   bdx_reg, bdx_next, bdy_reg, bdy_next;
    logic        [HB-1:0] half_reg, half_next;
    logic [COLOR_W-1:0]   color_reg, color_next;

    logic signed [C:0]    diff_x, diff_y;
    logic signed [C:0]    abs_x, abs_y;
    logic [TCW-1:0]       th_ext, th_clamp;
    logic [HB-1:0]        half_new;
    logic signed [HB:0]   half_s;
    logic                 dx_end, dy_end, at_target;
    logic signed [EW:0]   e2, dx_s, dy_s;
    logic                 take_x, take_y;
    logic signed [EW-1:0] err_upd;

    always_comb
    begin
        // start set-up
        diff_x   = (C+1)'(end_x) - (C+1)'(start_x);
        diff_y   = (C+1)'(end_y) - (C+1)'(start_y);
        abs_x    = diff_x[C] ? -diff_x : diff_x;
        abs_y    = diff_y[C] ? -diff_y : diff_y;
        th_ext   = TCW'(thickness);
        th_clamp = (th_ext > TCW'(MAX_THICKNESS)) ? TCW'(MAX_THICKNESS) : th_ext;
        half_new = HB'(th_clamp >> 1);

        // brush and point step
        half_s    = $signed({1'b0, half_reg});
        dx_end    = (bdx_reg == half_s);
        dy_end    = (bdy_reg == half_s);
        at_target = (px_reg == tx_reg) && (py_reg == ty_reg);
        e2        = {err_reg, 1'b0};
        dx_s      = $signed((EW+1)'(dx_reg));
        dy_s      = $signed((EW+1)'(dy_reg));
        take_x    = (e2 > -dy_s);
        take_y    = (e2 < dx_s);
        err_upd   = err_reg - (take_x ? EW'(dy_s) : '0) + (take_y ? EW'(dx_s) : '0);

        pix_valid = step && (op == OP_ADVANCE) && active_reg;
        pix_x     = SW'(px_reg) + SW'(bdx_reg);
        pix_y     = SW'(py_reg) + SW'(bdy_reg);
        pix_color = color_reg;
        pix_last  = dx_end && dy_end && at_target;
    end

    always_comb
    begin
        active_next = active_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        signs_next  = signs_reg;
        err_next    = err_reg;
        bdx_next    = bdx_reg;
        bdy_next    = bdy_reg;
        half_next   = half_reg;
        color_next  = color_reg;

        if (step && (op == OP_START))
        begin
            px_next     = start_x;
            py_next     = start_y;
            tx_next     = end_x;
            ty_next     = end_y;
            dx_next     = abs_x[C-1:0];
            dy_next     = abs_y[C-1:0];
            signs_next  = {(start_y >= end_y), (start_x >= end_x)};
            err_next    = EW'(abs_x) - EW'(abs_y);
            half_next   = half_new;
            bdx_next    = -$signed({1'b0, half_new});
            bdy_next    = -$signed({1'b0, half_new});
            color_next  = color;
            active_next = 1'b1;
        end
        else if (pix_valid)
        begin
            if (!dx_end)
            begin
                bdx_next = bdx_reg + (HB+1)'(1);
            end
            else
            begin
                bdx_next = -half_s;
                if (!dy_end)
                begin
                    bdy_next = bdy_reg + (HB+1)'(1);
                end
                else
                begin
                    bdy_next = -half_s;
                    if (at_target)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        err_next = err_upd;
                        if (take_x)
                        begin
                            px_next = signs_reg[0] ? px_reg - C'(1) : px_reg + C'(1);
                        end
                        if (take_y)
                        begin
                            py_next = signs_reg[1] ? py_reg - C'(1) : py_reg + C'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            px_reg     <= '0;
            py_reg     <= '0;
            tx_reg     <= '0;
            ty_reg     <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            signs_reg  <= '0;
            err_reg    <= '0;
            bdx_reg    <= '0;
            bdy_reg    <= '0;
            half_reg   <= '0;
            color_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            signs_reg  <= signs_next;
            err_reg    <= err_next;
            bdx_reg    <= bdx_next;
            bdy_reg    <= bdy_next;
            half_reg   <= half_next;
            color_reg  <= color_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/thk_clip.sv =====
// thk_clip: frame clipping and linear pixel address.
// Depends on thk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thk_clip
    import thk_pkg::*;
#(
    parameter int SW = 15
)
(
    input  wire signed [SW-1:0]  pix_x,
    input  wire signed [SW-1:0]  pix_y,
    input  wire [CFG_W-1:0]      frame_width,
    input  wire [CFG_W-1:0]      frame_height,
    input  wire [COLOR_W-1:0]    color,
    input  wire                  last,
    output thk_res_t             res
);

    localparam int CMPW = (SW > CFG_W + 1) ? SW : CFG_W + 1;
    localparam int PW   = 2 * CFG_W;

    logic [CMPW-1:0] xu, yu;
    logic            in_frame;
    logic [PW-1:0]   prod, sum;

    always_comb
    begin
        xu       = CMPW'($unsigned(pix_x));
        yu       = CMPW'($unsigned(pix_y));
        in_frame = !pix_x[SW-1] && !pix_y[SW-1]
                   && (xu < CMPW'(frame_width)) && (yu < CMPW'(frame_height));
        // inside the frame both coordinates fit the config width
        prod     = PW'(yu[CFG_W-1:0]) * PW'(frame_width);
        sum      = prod + PW'(xu[CFG_W-1:0]);

        res.addr  = in_frame ? sum[ADDR_W-1:0] : '0;
        res.color = color;
        res.we    = in_frame;
        res.last  = last;
    end

endmodule

`default_nettype wire

// ===== rtl/core/thk_outq.sv =====
// thk_outq: two-beat result queue decoupling the pixel stage from the
// output stream. Depends on thk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thk_outq
    import thk_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire       push,
    input  thk_res_t  push_data,
    output logic      space,
    output logic      out_valid,
    input  wire       out_ready,
    output thk_res_t  out_data
);

    thk_res_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    always_comb
    begin
        space       = (cnt_reg != 2'd2);
        out_valid   = (cnt_reg != 2'd0);
        out_data    = entry_reg[rd_ptr_reg];
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/thick_line_rasterizer.sv =====
// thick_line_rasterizer: top level. Input register, line walker, clipper
// and result queue. Depends on thk_pkg, thk_walk, thk_clip, thk_outq.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready  | tuser: operation; tdata: endpoints,
//          |     |                       | colour, thickness
//  m_axis  | out | m_axis_tvalid/tready  | tdata: address, colour;
//          |     |                       | tuser: write_enable; tlast: last_pixel
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (frame size)
//
// One input beat per clock while the result queue has a free slot. A beat is
// held in the input register, then walker and clipper produce its pixel into
// the two-beat result queue, from which it appears on m_axis.
// Start beats and advances while idle yield no output beat.
// Reset (rst_n, async, active low) idles the walker, empties the queue and
// restores frame size 1024 x 768. cfg_ready is always high.
// The input register only moves on while the queue has a free slot, so an
// output stall drops s_axis_tready once both queue slots and the input
// register hold a beat.
`timescale 1ns / 1ps
`default_nettype none

module thick_line_rasterizer
    import thk_pkg::*;
#(
    parameter int COORD_BITS    = 13,
    parameter int MAX_THICKNESS = 63,
    localparam int IN_BITS      = 4 * COORD_BITS + COLOR_W + THICK_W,
    localparam int IN_W         = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W        = ((ADDR_W + COLOR_W + 7) / 8) * 8
)
(
    input  wire                  clk,
    input  wire                  rst_n,

    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // start_x, start_y, end_x, end_y, color, thickness (lowest first)
    input  wire [IN_W-1:0]       s_axis_tdata,
    // operation
    input  wire [0:0]            s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // pixel_address, pixel_color (lowest first)
    output logic [OUT_W-1:0]     m_axis_tdata,
    // write_enable
    output logic [0:0]           m_axis_tuser,
    output logic                 m_axis_tlast,

    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_W-1:0]      cfg_data
);

    localparam int C        = COORD_BITS;
    localparam int HALF_MAX = MAX_THICKNESS / 2;
    localparam int HB       = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
    localparam int SW       = ((C > HB + 1) ? C : HB + 1) + 1;
    localparam int OFF_SY   = C;
    localparam int OFF_EX   = 2 * C;
    localparam int OFF_EY   = 3 * C;
    localparam int OFF_COL  = 4 * C;
    localparam int OFF_TH   = 4 * C + COLOR_W;

    // frame size registers
    logic [CFG_W-1:0] fw_reg, fw_next, fh_reg, fh_next;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic               in_op_reg;
    logic [IN_BITS-1:0] in_data_reg;
    logic               in_take, step, q_space;

    logic                  pix_valid, pix_last;
    logic signed [SW-1:0]  pix_x, pix_y;
    logic [COLOR_W-1:0]    pix_color;
    thk_res_t              res, q_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_next = cfg_data;
                REG_FRAME_HEIGHT: fh_next = cfg_data;
                default:          ;   // unknown index: ignored
            endcase
        end
    end

    // input stage advances whenever the queue can take a pixel
    always_comb
    begin
        step          = in_valid_reg && q_space;
        s_axis_tready = !in_valid_reg || q_space;
        in_take       = s_axis_tvalid && s_axis_tready;
        in_valid_next = in_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= s_axis_tuser[0];
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            fw_reg       <= FRAME_WIDTH_RST;
            fh_reg       <= FRAME_HEIGHT_RST;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            fw_reg       <= fw_next;
            fh_reg       <= fh_next;
        end
    end

    thk_walk #(
        .COORD_BITS    (COORD_BITS),
        .MAX_THICKNESS (MAX_THICKNESS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .op        (in_op_reg),
        .start_x   ($signed(in_data_reg[C-1:0])),
        .start_y   ($signed(in_data_reg[OFF_SY +: C])),
        .end_x     ($signed(in_data_reg[OFF_EX +: C])),
        .end_y     ($signed(in_data_reg[OFF_EY +: C])),
        .color     (in_data_reg[OFF_COL +: COLOR_W]),
        .thickness (in_data_reg[OFF_TH +: THICK_W]),
        .pix_valid (pix_valid),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_color (pix_color),
        .pix_last  (pix_last)
    );

    thk_clip #(
        .SW (SW)
    ) u_clip (
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .frame_width  (fw_reg),
        .frame_height (fh_reg),
        .color        (pix_color),
        .last         (pix_last),
        .res          (res)
    );

    thk_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pix_valid),
        .push_data (res),
        .space     (q_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (q_data)
    );

    always_comb
    begin
        m_axis_tdata    = OUT_W'({q_data.color, q_data.addr});
        m_axis_tuser[0] = q_data.we;
        m_axis_tlast    = q_data.last;
    end

endmodule

`default_nettype wire

// ===== dv/thk_line_checker.sv =====
`timescale 1ns / 1ps
// thk_line_checker: scoreboard for thick_line_rasterizer. Follows frame size
// writes, predicts each brush pixel and compares the m_axis beats. Needs thk_pkg.

module thk_line_checker
    import thk_pkg::*;
#(
    parameter int COORD_BITS    = 13,
    parameter int MAX_THICKNESS = 63,
    parameter int IN_W          = 96,
    parameter int OUT_W         = 56
)
(
    input  wire                  clk,
    input  wire                  rst_n,

    input  wire                  s_axis_tvalid,
    input  wire                  s_axis_tready,
    input  wire [IN_W-1:0]       s_axis_tdata,
    input  wire [0:0]            s_axis_tuser,

    input  wire                  m_axis_tvalid,
    input  wire                  m_axis_tready,
    input  wire [OUT_W-1:0]      m_axis_tdata,
    input  wire [0:0]            m_axis_tuser,
    input  wire                  m_axis_tlast,

    input  wire                  cfg_valid,
    input  wire                  cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_W-1:0]      cfg_data,

    output int                   mismatches,
    output int                   pending,
    output int                   pixels_checked,
    output int                   pixels_written
);

    localparam int CB = COORD_BITS;

    logic [CFG_W-1:0]      frame_w = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]      frame_h = FRAME_HEIGHT_RST;
    logic                  line_active = 1'b0;
    logic signed [CB:0]    point_x, point_y;
    logic signed [CB-1:0]  target_x, target_y;
    logic [CB-1:0]         delta_x, delta_y;
    logic [1:0]            step_signs;     // bit 0: x walks down, bit 1: y walks down
    logic signed [15:0]    error_term;
    logic signed [6:0]     brush_dx, brush_dy;
    logic [4:0]            brush_half;
    logic [COLOR_W-1:0]    line_color;
    thk_res_t              pixel_q[$];

    function automatic int coord(input logic [IN_W-1:0] d, input int slot);
        logic signed [CB-1:0] c;
        c = d[slot*CB +: CB];
        return int'(c);
    endfunction

    task automatic load_line(input logic [IN_W-1:0] d);
        int sx, sy, ex, ey, th;
        sx = coord(d, 0);
        sy = coord(d, 1);
        ex = coord(d, 2);
        ey = coord(d, 3);
        th = int'(d[4*CB+COLOR_W +: THICK_W]);
        if (th > MAX_THICKNESS)
            th = MAX_THICKNESS;
        point_x    = (CB+1)'(sx);
        point_y    = (CB+1)'(sy);
        target_x   = CB'(ex);
        target_y   = CB'(ey);
        delta_x    = CB'((ex > sx) ? ex - sx : sx - ex);
        delta_y    = CB'((ey > sy) ? ey - sy : sy - ey);
        step_signs = {sy >= ey, sx >= ex};
        error_term = 16'(int'(delta_x) - int'(delta_y));
        brush_half = 5'(th / 2);
        brush_dx   = 7'(-(th / 2));
        brush_dy   = 7'(-(th / 2));
        line_color = d[4*CB +: COLOR_W];
        line_active = 1'b1;
    endtask

    // One brush pixel around the current point, then walk brush and line.
    task automatic next_pixel();
        int px, py, hb, bx, by, e2;
        thk_res_t r;
        hb = int'(brush_half);
        px = int'(point_x) + int'(brush_dx);
        py = int'(point_y) + int'(brush_dy);
        r.we    = (px >= 0 && py >= 0 && px < int'(frame_w) && py < int'(frame_h));
        r.addr  = r.we ? ADDR_W'(py * int'(frame_w) + px) : '0;
        r.color = line_color;
        r.last  = 1'b0;
        bx = int'(brush_dx) + 1;
        by = int'(brush_dy);
        if (bx > hb) begin
            bx = -hb;
            by++;
            if (by > hb) begin
                by = -hb;
                if (int'(point_x) == int'(target_x) && int'(point_y) == int'(target_y)) begin
                    r.last = 1'b1;
                    line_active = 1'b0;
                end
                else begin
                    e2 = 2 * int'(error_term);
                    if (e2 > -int'(delta_y)) begin
                        error_term = 16'(int'(error_term) - int'(delta_y));
                        point_x = (CB+1)'(int'(point_x) + (step_signs[0] ? -1 : 1));
                    end
                    if (e2 < int'(delta_x)) begin
                        error_term = 16'(int'(error_term) + int'(delta_x));
                        point_y = (CB+1)'(int'(point_y) + (step_signs[1] ? -1 : 1));
                    end
                end
            end
        end
        brush_dx = 7'(bx);
        brush_dy = 7'(by);
        pixel_q.push_back(r);
    endtask

    task automatic check_pixel();
        thk_res_t want, got;
        got.addr  = m_axis_tdata[0 +: ADDR_W];
        got.color = m_axis_tdata[ADDR_W +: COLOR_W];
        got.we    = m_axis_tuser[0];
        got.last  = m_axis_tlast;
        pixels_checked++;
        if (got.we)
            pixels_written++;
        if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: pixel beat with none owed: addr %h colour %h we %b last %b",
                         $time, got.addr, got.color, got.we, got.last);
            return;
        end
        want = pixel_q.pop_front();
        if (got.addr !== want.addr || got.color !== want.color ||
            got.we !== want.we || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: pixel %0d expected addr %h colour %h we %b last %b, got %h %h %b %b",
                         $time, pixels_checked, want.addr, want.color, want.we, want.last,
                         got.addr, got.color, got.we, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w     = FRAME_WIDTH_RST;
            frame_h     = FRAME_HEIGHT_RST;
            line_active = 1'b0;
            point_x     = '0;
            point_y     = '0;
            target_x    = '0;
            target_y    = '0;
            delta_x     = '0;
            delta_y     = '0;
            step_signs  = '0;
            error_term  = '0;
            brush_dx    = '0;
            brush_dy    = '0;
            brush_half  = '0;
            line_color  = '0;
            pixel_q.delete();
            pending     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    frame_w = cfg_data;
                else if (cfg_index == REG_FRAME_HEIGHT)
                    frame_h = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == OP_START)
                    load_line(s_axis_tdata);
                else if (line_active)
                    next_pixel();
            end
            if (m_axis_tvalid && m_axis_tready)
                check_pixel();
            pending = pixel_q.size();
        end
    end

endmodule

// ===== dv/tb_thick_line_rasterizer.sv =====
`timescale 1ns / 1ps
// tb_thick_line_rasterizer: stimulus, flow control and verdict for the thick
// line rasteriser. Needs thk_pkg, thick_line_rasterizer and thk_line_checker.

module tb_thick_line_rasterizer;
    import thk_pkg::*;

    localparam int COORD_BITS    = 13;
    localparam int MAX_THICKNESS = 63;
    localparam int CB            = COORD_BITS;
    localparam int IN_W          = ((4 * CB + COLOR_W + THICK_W + 7) / 8) * 8;
    localparam int OUT_W         = ((ADDR_W + COLOR_W + 7) / 8) * 8;
    localparam int COORD_MIN     = -(1 << (CB - 1));
    localparam int COORD_MAX     = (1 << (CB - 1)) - 1;
    localparam int THICK_TOP     = (1 << THICK_W) - 1;
    localparam int CFG_TOP       = (1 << CFG_W) - 1;

    localparam int RANDOM_ITEMS  = 1800;   // starts plus advances inside a line
    localparam int PHASES        = 8;
    localparam int IDLE_LIMIT    = 5000;   // cycles without any beat
    localparam int SETTLE_CYCLES = 6;      // pipeline is two deep, start beats give nothing
    localparam int TAIL_CYCLES   = 10;
    localparam int LONG_LINE     = 600;    // brush pixels above which a line is cut short

    // indexes the block does not decode; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  clk;
    logic                  rst_n;

    logic                  s_axis_tvalid;
    wire                   s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;    // start_x, start_y, end_x, end_y, color, thickness
    logic [0:0]            s_axis_tuser;    // operation

    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    wire  [OUT_W-1:0]      m_axis_tdata;    // pixel_address, pixel_color
    wire  [0:0]            m_axis_tuser;    // write_enable
    wire                   m_axis_tlast;    // last_pixel

    logic                  cfg_valid;
    wire                   cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int mismatches, pending, pixels_checked, pixels_written;

    // flow control: percentage of cycles each side holds back
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;

    int line_items    = 0;   // beats of the random part that the block acts on
    int lines_started = 0;
    int fw_now        = FRAME_WIDTH_RST;
    int fh_now        = FRAME_HEIGHT_RST;

    thick_line_rasterizer #(
        .COORD_BITS    (COORD_BITS),
        .MAX_THICKNESS (MAX_THICKNESS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    thk_line_checker #(
        .COORD_BITS    (COORD_BITS),
        .MAX_THICKNESS (MAX_THICKNESS),
        .IN_W          (IN_W),
        .OUT_W         (OUT_W)
    ) chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .pixels_checked (pixels_checked),
        .pixels_written (pixels_written)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Receiver: back-pressure decided afresh every falling edge.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);

    function automatic int clamp_coord(input int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Coordinate in or just around a frame edge of the given extent.
    function automatic int near_frame(input int extent);
        int hi;
        hi = (extent > COORD_MAX) ? COORD_MAX : extent;
        return clamp_coord(int'($urandom_range(hi + 12)) - 6);
    endfunction

    function automatic int any_coord();
        return int'($urandom_range((1 << CB) - 1)) + COORD_MIN;
    endfunction

    // One s_axis beat: optional idle gap, then hold until accepted.
    // Returns on the falling edge after the accepting edge, tvalid still high.
    task automatic send_beat(input logic op, input logic [IN_W-1:0] data);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic start_line(input int sx, input int sy, input int ex, input int ey,
                              input logic [COLOR_W-1:0] col, input int th);
        logic [IN_W-1:0] d;
        d = '0;
        d[0*CB +: CB]              = CB'(sx);
        d[1*CB +: CB]              = CB'(sy);
        d[2*CB +: CB]              = CB'(ex);
        d[3*CB +: CB]              = CB'(ey);
        d[4*CB +: COLOR_W]         = col;
        d[4*CB+COLOR_W +: THICK_W] = THICK_W'(th);
        send_beat(OP_START, d);
        lines_started++;
    endtask

    // tdata is don't-care on an advance, so fill it with noise
    task automatic advance_beats(input int n);
        repeat (n)
            send_beat(OP_ADVANCE, IN_W'({$urandom, $urandom, $urandom}));
    endtask

    // Sender holds off until every owed pixel is out, then lets the pipe empty.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic configure_frame(input int w, input int h, input bit poke_spare);
        settle();
        if (poke_spare)
        begin
            write_reg(REG_SPARE_2, int'($urandom_range(CFG_TOP)));
            write_reg(REG_SPARE_3, int'($urandom_range(CFG_TOP)));
        end
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        cfg_valid = 1'b0;
        fw_now = w;
        fh_now = h;
    endtask

    task automatic set_flow(input int mode);
        case (mode)
            0:
            begin
                snd_idle_pct  = 0;
                rcv_stall_pct = 0;
            end
            1:
            begin
                snd_idle_pct  = 78;
                rcv_stall_pct = 0;
            end
            2:
            begin
                snd_idle_pct  = 0;
                rcv_stall_pct = 78;
            end
            default:
            begin
                snd_idle_pct  = 27;
                rcv_stall_pct = 27;
            end
        endcase
    endtask

    // Hand-picked lines under the reset frame of 1024 x 768.
    task automatic directed_lines();
        // advance with no line loaded: nothing comes out
        advance_beats(1);
        // corner to corner at full thickness and all-ones colour, cut short
        start_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, '1, THICK_TOP);
        advance_beats(3);
        // new start drops that line; single point, then an advance past the end
        start_line(0, 0, 0, 0, '0, 1);
        advance_beats(2);
        // last visible pixel, then one step off the bottom right corner
        start_line(FRAME_WIDTH_RST - 1, FRAME_HEIGHT_RST - 1,
                   FRAME_WIDTH_RST, FRAME_HEIGHT_RST, 32'hA5A5_5A5A, 0);
        advance_beats(2);
        // 3 x 3 brush at the origin, clipped on the top and left
        start_line(0, 0, 0, 0, 32'h0F0F_F0F0, 2);
        advance_beats(9);
        // opposite diagonal, wide brush, left to be abandoned by the next start
        start_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32'h1234_5678, THICK_TOP - 1);
        advance_beats(2);
    endtask

    // Mostly complete short lines; some cut short, some followed by stray
    // advances, a few with endpoints anywhere in the coordinate range.
    task automatic random_line();
        int sx, sy, ex, ey, th, half, adx, ady, span, pixels, roll, n;
        logic [COLOR_W-1:0] col;
        roll = $urandom_range(99);
        if (roll < 70)
            th = $urandom_range(4);
        else if (roll < 90)
            th = $urandom_range(9, 5);
        else
            th = $urandom_range(THICK_TOP);
        if ($urandom_range(1))
        begin
            sx = near_frame(fw_now);
            sy = near_frame(fh_now);
        end
        else
        begin
            sx = any_coord();
            sy = any_coord();
        end
        if ($urandom_range(99) < 3)
        begin
            ex = any_coord();
            ey = any_coord();
        end
        else
        begin
            ex = clamp_coord(sx + int'($urandom_range(24)) - 12);
            ey = clamp_coord(sy + int'($urandom_range(24)) - 12);
        end
        col  = $urandom;
        half = th / 2;
        adx  = (ex > sx) ? ex - sx : sx - ex;
        ady  = (ey > sy) ? ey - sy : sy - ey;
        span = ((adx > ady) ? adx : ady) + 1;
        pixels = (2 * half + 1) * (2 * half + 1) * span;

        start_line(sx, sy, ex, ey, col, th);
        line_items++;
        roll = $urandom_range(99);
        if (pixels > LONG_LINE || roll < 10)
        begin
            n = $urandom_range((pixels - 1 > 40) ? 40 : pixels - 1);
            advance_beats(n);
            line_items += n;
        end
        else
        begin
            advance_beats(pixels);
            line_items += pixels;
            // strays after the end; the block ignores them
            if (roll < 20)
                advance_beats($urandom_range(3, 1));
        end
    endtask

    // Watchdog: a stretch with no beat on any channel ends the run.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a beat, %0d pixels still owed",
                 IDLE_LIMIT, pending);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int phase;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        cfg_valid     = 1'b0;
        cfg_index     = REG_FRAME_WIDTH;
        cfg_data      = '0;
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_lines();

        // Each phase after phase 0: new frame size while idle, a flow-control mix, then its
        // share of random lines. Phases 0 and 4 run with no idling at all.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1: configure_frame(1, 1, 1'b0);
                2: configure_frame(4096, 4096, 1'b0);
                3: configure_frame(0, int'($urandom_range(4096, 1)), 1'b0);
                4: configure_frame(CFG_TOP, CFG_TOP, 1'b0);   // address wraps
                5: configure_frame(int'($urandom_range(4096, 1)), 0, 1'b1);
                6: configure_frame(int'($urandom_range(4096, 1)),
                                   int'($urandom_range(4096, 1)), 1'b1);
                7: configure_frame(640, 480, 1'b0);
                default:
                begin
                end
            endcase
            set_flow(phase % 4);
            while (line_items < (phase + 1) * RANDOM_ITEMS / PHASES)
                random_line();
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);

        $display("covered %0d line starts and %0d pixel beats, %0d of them inside the frame",
                 lines_started, pixels_checked, pixels_written);
        $display("over %0d frame sizes incl. zero and oversized, with four back-pressure mixes",
                 PHASES);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
